// File: design/uartrb_pkg.sv
// Shared types and constants for the UART transmit and receive ring buffers.
`default_nettype none

package uartrb_pkg;

  localparam int unsigned DEFAULT_RING_DEPTH = 256;
  localparam int unsigned DATA_W             = 8;
  localparam int unsigned LEVEL_W            = 9;
  localparam int unsigned STATUS_W           = 3;

  typedef enum logic [1:0] {
    OP_PUT      = 2'd0,
    OP_GET      = 2'd1,
    OP_TX_READY = 2'd2,
    OP_RX_BYTE  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_TX_FULL  = 3'd1,
    ST_RX_EMPTY = 3'd2,
    ST_NOT_SENT = 3'd3,
    ST_RX_DROP  = 3'd4
  } status_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_RESP = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [DATA_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
    logic                send_valid;
    logic                tx_irq_enabled;
    logic [LEVEL_W-1:0]  tx_level;
    logic [LEVEL_W-1:0]  rx_level;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic load_out;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// File: design/uartrb_ram.sv
// Single-port-write, single-port-read byte memory with registered read data.
`default_nettype none

module uartrb_ram #(
  parameter int unsigned DEPTH = uartrb_pkg::DEFAULT_RING_DEPTH,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          wr_en_i,
  input  wire logic [IDX_W-1:0]              wr_addr_i,
  input  wire logic [uartrb_pkg::DATA_W-1:0] wr_data_i,
  input  wire logic                          rd_en_i,
  input  wire logic [IDX_W-1:0]              rd_addr_i,
  output      logic [uartrb_pkg::DATA_W-1:0] rd_data_o
);

  logic [uartrb_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [uartrb_pkg::DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: design/uartrb_ctrl.sv
// Handshake controller: accepts one word, then loads the result register.
`default_nettype none

module uartrb_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      uartrb_pkg::ctrl_cmd_t cmd_o
);

  uartrb_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uartrb_pkg::CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready     = 1'b0;
    cmd_o.accept   = 1'b0;
    cmd_o.load_out = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      uartrb_pkg::CS_IDLE: begin
        // The result register is free next cycle if it is empty or drains now.
        in_ready = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready) begin
          cmd_o.accept = 1'b1;
          state_d      = uartrb_pkg::CS_RESP;
        end
      end
      uartrb_pkg::CS_RESP: begin
        cmd_o.load_out = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = uartrb_pkg::CS_IDLE;
      end
      default: begin
        state_d = uartrb_pkg::CS_IDLE;
      end
    endcase
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: design/uartrb_dp.sv
// Datapath: ring pointers, interrupt enable, both byte memories, result register.
`default_nettype none

module uartrb_dp #(
  parameter int unsigned RING_DEPTH = uartrb_pkg::DEFAULT_RING_DEPTH,
  localparam int unsigned IDX_W = $clog2(RING_DEPTH),
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1),
  localparam int unsigned LVL_W = (CNT_W > uartrb_pkg::LEVEL_W) ? CNT_W : uartrb_pkg::LEVEL_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire uartrb_pkg::ctrl_cmd_t cmd_i,
  input  wire uartrb_pkg::in_word_t  in_word_i,
  output      uartrb_pkg::out_word_t out_word_o
);

  // Each pointer is a wrap bit above a slot index.
  logic [IDX_W:0] tx_w_q, tx_w_d, tx_r_q, tx_r_d;
  logic [IDX_W:0] rx_w_q, rx_w_d, rx_r_q, rx_r_d;
  logic           irq_q, irq_d;

  logic [uartrb_pkg::STATUS_W-1:0] status_q, status_d;
  logic                            rd_hit_q, rd_hit_d;
  logic                            rd_tx_q, rd_tx_d;
  logic                            sent_q, sent_d;

  logic tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
  logic [uartrb_pkg::DATA_W-1:0] tx_rd_data, rx_rd_data;
  logic tx_empty, tx_full, rx_empty, rx_full;

  uartrb_pkg::out_word_t out_q, out_d;

  function automatic logic [IDX_W:0] ptr_next(input logic [IDX_W:0] p);
    if (p[IDX_W-1:0] == IDX_W'(RING_DEPTH - 1)) begin
      return {~p[IDX_W], {IDX_W{1'b0}}};
    end else begin
      return {p[IDX_W], p[IDX_W-1:0] + 1'b1};
    end
  endfunction

  function automatic logic [uartrb_pkg::LEVEL_W-1:0] level_of(input logic [IDX_W:0] w,
                                                              input logic [IDX_W:0] r);
    logic [LVL_W-1:0] lvl;
    if (w[IDX_W] == r[IDX_W]) begin
      lvl = LVL_W'(w[IDX_W-1:0]) - LVL_W'(r[IDX_W-1:0]);
    end else begin
      lvl = LVL_W'(w[IDX_W-1:0]) + LVL_W'(RING_DEPTH) - LVL_W'(r[IDX_W-1:0]);
    end
    return lvl[uartrb_pkg::LEVEL_W-1:0];
  endfunction

  assign tx_empty = (tx_w_q == tx_r_q);
  assign rx_empty = (rx_w_q == rx_r_q);
  assign tx_full  = (tx_w_q[IDX_W] != tx_r_q[IDX_W]) &&
                    (tx_w_q[IDX_W-1:0] == tx_r_q[IDX_W-1:0]);
  assign rx_full  = (rx_w_q[IDX_W] != rx_r_q[IDX_W]) &&
                    (rx_w_q[IDX_W-1:0] == rx_r_q[IDX_W-1:0]);

  always_comb begin
    tx_w_d   = tx_w_q;
    tx_r_d   = tx_r_q;
    rx_w_d   = rx_w_q;
    rx_r_d   = rx_r_q;
    irq_d    = irq_q;
    status_d = status_q;
    rd_hit_d = rd_hit_q;
    rd_tx_d  = rd_tx_q;
    sent_d   = sent_q;
    tx_wr_en = 1'b0;
    tx_rd_en = 1'b0;
    rx_wr_en = 1'b0;
    rx_rd_en = 1'b0;
    if (cmd_i.accept) begin
      status_d = uartrb_pkg::ST_OK;
      rd_hit_d = 1'b0;
      rd_tx_d  = 1'b0;
      sent_d   = 1'b0;
      unique case (uartrb_pkg::op_e'(in_word_i.opcode))
        uartrb_pkg::OP_PUT: begin
          if (tx_full) begin
            status_d = uartrb_pkg::ST_TX_FULL;
          end else begin
            tx_wr_en = 1'b1;
            tx_w_d   = ptr_next(tx_w_q);
            irq_d    = 1'b1;
          end
        end
        uartrb_pkg::OP_GET: begin
          if (rx_empty) begin
            status_d = uartrb_pkg::ST_RX_EMPTY;
          end else begin
            rx_rd_en = 1'b1;
            rd_hit_d = 1'b1;
            rx_r_d   = ptr_next(rx_r_q);
          end
        end
        uartrb_pkg::OP_TX_READY: begin
          if (irq_q && !tx_empty) begin
            tx_rd_en = 1'b1;
            rd_hit_d = 1'b1;
            rd_tx_d  = 1'b1;
            sent_d   = 1'b1;
            tx_r_d   = ptr_next(tx_r_q);
            if (tx_r_d == tx_w_q) begin
              irq_d = 1'b0;
            end
          end else begin
            status_d = uartrb_pkg::ST_NOT_SENT;
          end
        end
        uartrb_pkg::OP_RX_BYTE: begin
          if (rx_full) begin
            status_d = uartrb_pkg::ST_RX_DROP;
          end else begin
            rx_wr_en = 1'b1;
            rx_w_d   = ptr_next(rx_w_q);
          end
        end
        default: begin
          status_d = uartrb_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_w_q <= '0;
      tx_r_q <= '0;
      rx_w_q <= '0;
      rx_r_q <= '0;
      irq_q  <= 1'b0;
    end else begin
      tx_w_q <= tx_w_d;
      tx_r_q <= tx_r_d;
      rx_w_q <= rx_w_d;
      rx_r_q <= rx_r_d;
      irq_q  <= irq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rd_hit_q <= rd_hit_d;
    rd_tx_q  <= rd_tx_d;
    sent_q   <= sent_d;
  end

  uartrb_ram #(.DEPTH(RING_DEPTH)) u_tx_ram (
    .clk_i     (clk_i),
    .wr_en_i   (tx_wr_en),
    .wr_addr_i (tx_w_q[IDX_W-1:0]),
    .wr_data_i (in_word_i.data_in),
    .rd_en_i   (tx_rd_en),
    .rd_addr_i (tx_r_q[IDX_W-1:0]),
    .rd_data_o (tx_rd_data)
  );

  uartrb_ram #(.DEPTH(RING_DEPTH)) u_rx_ram (
    .clk_i     (clk_i),
    .wr_en_i   (rx_wr_en),
    .wr_addr_i (rx_w_q[IDX_W-1:0]),
    .wr_data_i (in_word_i.data_in),
    .rd_en_i   (rx_rd_en),
    .rd_addr_i (rx_r_q[IDX_W-1:0]),
    .rd_data_o (rx_rd_data)
  );

  // Pointers and the enable already hold the post-item values here.
  always_comb begin
    out_d.status         = status_q;
    out_d.data_out       = rd_hit_q ? (rd_tx_q ? tx_rd_data : rx_rd_data) : '0;
    out_d.send_valid     = sent_q;
    out_d.tx_irq_enabled = irq_q;
    out_d.tx_level       = level_of(tx_w_q, tx_r_q);
    out_d.rx_level       = level_of(rx_w_q, rx_r_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

// File: design/uart_tx_rx_ring_buffers.sv
// Top level of the UART transmit and receive ring buffers.
`default_nettype none

// Two byte rings of RING_DEPTH entries sit between software and a UART. Every
// input word carries an opcode: put queues data_in for sending and sets the
// transmit interrupt enable, get returns the oldest received byte, transmitter
// ready hands the oldest queued byte to the line while the enable is set, and
// byte received queues data_in in the receive ring. Every input word yields
// exactly one result word with a status code, the byte read or sent, the enable
// and both ring levels after the operation. The accept cycle updates the
// pointers and starts the ring memory access, and the CS_RESP state then loads
// the result register from the registered memory read data. No word is
// accepted in CS_RESP, and in CS_IDLE only while the result register is free;
// the result register lets the next word in while the previous result is being
// taken. Ring contents are not cleared at reset and need no clearing pass,
// since a slot is only read after it was written.

module uart_tx_rx_ring_buffers #(
  parameter int unsigned RING_DEPTH = uartrb_pkg::DEFAULT_RING_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire uartrb_pkg::in_word_t  in_word_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      uartrb_pkg::out_word_t out_word_o
);

  // Command path from the controller into the datapath.
  uartrb_pkg::ctrl_cmd_t cmd;

  uartrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  uartrb_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

// File: design/uartrb_checker.sv
// Port-level checks for the UART ring buffers and their bind to the top level.
`default_nettype none

module uartrb_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire uartrb_pkg::out_word_t out_word_o
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // A word is processed through the CS_IDLE and CS_RESP states, so no back-to-back accept.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted in the cycle after an accept");

  // A failed operation returns no data.
  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != uartrb_pkg::ST_OK) |->
      (out_word_o.data_out == '0) && !out_word_o.send_valid)
    else $error("data returned with an error status");

  // The enable drops when the transmit ring empties.
  a_irq_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.tx_irq_enabled |-> out_word_o.tx_level != '0)
    else $error("transmit interrupt enabled with an empty ring");

endmodule

bind uart_tx_rx_ring_buffers uartrb_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
